@@ rtl/tcw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: screen geometry,
// command and register codes, channel payloads and control structs.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;
  localparam int CELL_W  = 16;
  // cells moved up by one scroll
  localparam int COPY_N  = (ROWS - 1) * COLUMNS;

  localparam logic [7:0] BLANK_CHAR = 8'h20;

  localparam logic [2:0] CMD_PUTCHAR   = 3'd0;
  localparam logic [2:0] CMD_BACKSPACE = 3'd1;
  localparam logic [2:0] CMD_CLEAR     = 3'd2;
  localparam logic [2:0] CMD_PUTAT     = 3'd3;
  localparam logic [2:0] CMD_READ      = 3'd4;

  localparam logic [1:0] CFG_TEXT_COLOR = 2'd0;
  localparam logic [1:0] CFG_PROT_COLS  = 2'd1;

  localparam logic [7:0] TEXT_COLOR_RESET = 8'd15;

  typedef struct packed {
    logic [2:0]       command;
    logic [7:0]       char_code;
    logic [7:0]       cell_color;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } req_t;

  typedef struct packed {
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic              scrolled;
    logic [CELL_W-1:0] cell_value;
  } rsp_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic idle;
    logic done;
    rsp_t result;
  } ctrl_status_t;

endpackage
`default_nettype wire

@@ rtl/tcw_screen_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_screen_ram
// Character-cell screen store: one write port and one registered read port.
// ----------------------------------------------------------------------------
module tcw_screen_ram (
  input  wire              clk,
  input  tcw_pkg::ram_req_t ram,
  output logic [tcw_pkg::CELL_W-1:0] rd_data
);
  import tcw_pkg::*;

  logic [CELL_W-1:0] mem [CELLS];

  always_ff @(posedge clk) begin
    if (ram.we) begin
      mem[ram.waddr] <= ram.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ram.re) begin
      rd_data <= mem[ram.raddr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/tcw_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_ctrl
// Command sequencer: owns the cursor, forms cell addresses with one shared
// address unit and walks the screen store for scroll and clear.
// ----------------------------------------------------------------------------
module tcw_ctrl (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      start,
  input  tcw_pkg::req_t            req,
  input  wire  [7:0]               text_color,
  input  wire  [tcw_pkg::COL_W-1:0] protected_columns,
  input  wire                      out_free,
  input  wire  [tcw_pkg::CELL_W-1:0] rd_data,
  output tcw_pkg::ram_req_t        ram,
  output tcw_pkg::ctrl_status_t    status
);
  import tcw_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_CALC   = 8'b0000_0010,
    ST_EXEC   = 8'b0000_0100,
    ST_RDWAIT = 8'b0000_1000,
    ST_COPY   = 8'b0001_0000,
    ST_FILL   = 8'b0010_0000,
    ST_CLEAR  = 8'b0100_0000,
    ST_FINISH = 8'b1000_0000
  } state_t;

  state_t            state;
  req_t              cmd_q;
  logic [ADDR_W-1:0] cnt;
  logic [ADDR_W-1:0] addr_q;
  logic              in_range_q;
  logic [ROW_W-1:0]  cur_row;
  logic [COL_W-1:0]  cur_col;
  logic              scrolled_q;
  logic [CELL_W-1:0] value_q;

  logic [ROW_W-1:0]  au_row;
  logic [COL_W-1:0]  au_col;
  logic [ADDR_W+1:0] au_addr;
  logic              bs_ok;
  logic [CELL_W-1:0] blank_cell;

  assign blank_cell = {text_color, BLANK_CHAR};
  assign bs_ok      = cur_col > protected_columns;

  // shared address unit: row * COLUMNS + col
  always_comb begin
    au_row = cur_row;
    au_col = cur_col;
    case (cmd_q.command)
      CMD_BACKSPACE: au_col = cur_col - COL_W'(1);
      CMD_PUTAT, CMD_READ: begin
        au_row = cmd_q.row;
        au_col = cmd_q.col;
      end
      default: ;
    endcase
    au_addr = (ADDR_W+2)'(au_row) * (ADDR_W+2)'(COLUMNS) + (ADDR_W+2)'(au_col);
  end

  always_comb begin
    ram = '0;
    unique case (state)
      ST_EXEC: begin
        ram.waddr = addr_q;
        ram.raddr = addr_q;
        case (cmd_q.command)
          CMD_PUTCHAR: begin
            ram.we    = 1'b1;
            ram.wdata = {text_color, cmd_q.char_code};
          end
          CMD_BACKSPACE: begin
            ram.we    = bs_ok;
            ram.wdata = blank_cell;
          end
          CMD_PUTAT: begin
            ram.we    = in_range_q;
            ram.wdata = {cmd_q.cell_color, cmd_q.char_code};
          end
          CMD_READ: ram.re = in_range_q;
          default: ;
        endcase
      end
      ST_COPY: begin
        // read one row ahead, write the beat read in the previous cycle
        ram.re    = cnt < ADDR_W'(COPY_N);
        ram.raddr = cnt + ADDR_W'(COLUMNS);
        ram.we    = cnt != '0;
        ram.waddr = cnt - ADDR_W'(1);
        ram.wdata = rd_data;
      end
      ST_FILL, ST_CLEAR: begin
        ram.we    = 1'b1;
        ram.waddr = cnt;
        ram.wdata = blank_cell;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cur_row    <= '0;
      cur_col    <= '0;
      cnt        <= '0;
      scrolled_q <= 1'b0;
      value_q    <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            cmd_q      <= req;
            scrolled_q <= 1'b0;
            value_q    <= '0;
            state      <= ST_CALC;
          end
        end
        ST_CALC: begin
          addr_q     <= au_addr[ADDR_W-1:0];
          in_range_q <= (cmd_q.row < ROW_W'(ROWS)) && (cmd_q.col < COL_W'(COLUMNS));
          state      <= ST_EXEC;
        end
        ST_EXEC: begin
          state <= ST_FINISH;
          case (cmd_q.command)
            CMD_PUTCHAR: begin
              if (cur_col == COL_W'(COLUMNS - 1)) begin
                cur_col <= '0;
                if (cur_row == ROW_W'(ROWS - 1)) begin
                  scrolled_q <= 1'b1;
                  cnt        <= '0;
                  state      <= ST_COPY;
                end else begin
                  cur_row <= cur_row + ROW_W'(1);
                end
              end else begin
                cur_col <= cur_col + COL_W'(1);
              end
            end
            CMD_BACKSPACE: begin
              if (bs_ok) begin
                cur_col <= cur_col - COL_W'(1);
              end
            end
            CMD_CLEAR: begin
              cur_row <= '0;
              cur_col <= '0;
              cnt     <= '0;
              state   <= ST_CLEAR;
            end
            CMD_READ: begin
              if (in_range_q) begin
                state <= ST_RDWAIT;
              end
            end
            default: ;
          endcase
        end
        ST_RDWAIT: begin
          value_q <= rd_data;
          state   <= ST_FINISH;
        end
        ST_COPY: begin
          if (cnt == ADDR_W'(COPY_N)) begin
            state <= ST_FILL;
          end else begin
            cnt <= cnt + ADDR_W'(1);
          end
        end
        ST_FILL, ST_CLEAR: begin
          if (cnt == ADDR_W'(CELLS - 1)) begin
            state <= ST_FINISH;
          end else begin
            cnt <= cnt + ADDR_W'(1);
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign status.idle              = state == ST_IDLE;
  assign status.done              = (state == ST_FINISH) && out_free;
  assign status.result.cursor_row = cur_row;
  assign status.result.cursor_col = cur_col;
  assign status.result.scrolled   = scrolled_q;
  assign status.result.cell_value = value_q;

  a_cursor_in_range: assert property (@(posedge clk) disable iff (rst)
    (cur_row < ROW_W'(ROWS)) && (cur_col < COL_W'(COLUMNS)))
    else $error("cursor left the screen");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    ram.we |-> (ram.waddr < ADDR_W'(CELLS)))
    else $error("write beyond the screen store");

  a_scroll_cursor: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL) |-> (cur_row == ROW_W'(ROWS - 1)) && (cur_col == '0))
    else $error("cursor not on the last row during scroll");

  a_read_then_wait: assert property (@(posedge clk) disable iff (rst)
    (ram.re && (state == ST_EXEC)) |=> (state == ST_RDWAIT))
    else $error("cell read not followed by data capture");

  a_scroll_flag: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COPY) |-> scrolled_q)
    else $error("scroll without scrolled flag");

endmodule
`default_nettype wire

@@ rtl/text_console_writer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console: screen store, cursor, configuration registers and a
// registered response beat.
// ----------------------------------------------------------------------------
// put char (no wrap off the last row), backspace, put at: CALC, EXEC and FINISH
//   states from accept to response, next command accepted once back in IDLE
// read: adds the RDWAIT state for the registered store read
// scroll: one cell per cycle
// clear: blanks every cell in the text color; screen contents undefined after rst,
//   rst homes the cursor and loads text_color 15, protected_columns 0
module text_console_writer (
  input  wire            clk,
  input  wire            rst,
  input  wire            req_valid,
  output logic           req_ready,
  input  tcw_pkg::req_t  req,
  output logic           rsp_valid,
  input  wire            rsp_ready,
  output tcw_pkg::rsp_t  rsp,
  input  wire            cfg_valid,
  output logic           cfg_ready,
  input  wire  [1:0]     cfg_index,
  input  wire  [7:0]     cfg_data
);
  import tcw_pkg::*;

  logic [7:0]        text_color;
  logic [COL_W-1:0]  protected_columns;
  logic [CELL_W-1:0] rd_data;
  ram_req_t          ram;
  ctrl_status_t      status;
  logic              out_free;

  assign cfg_ready = 1'b1;
  assign req_ready = status.idle;
  assign out_free  = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color        <= TEXT_COLOR_RESET;
      protected_columns <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TEXT_COLOR: text_color        <= cfg_data;
        CFG_PROT_COLS:  protected_columns <= cfg_data[COL_W-1:0];
        default: ;
      endcase
    end
  end

  // response register, refilled in the cycle its beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (status.done) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (status.done) begin
      rsp <= status.result;
    end
  end

  tcw_ctrl u_ctrl (
    .clk               (clk),
    .rst               (rst),
    .start             (req_valid && req_ready),
    .req               (req),
    .text_color        (text_color),
    .protected_columns (protected_columns),
    .out_free          (out_free),
    .rd_data           (rd_data),
    .ram               (ram),
    .status            (status)
  );

  tcw_screen_ram u_ram (
    .clk     (clk),
    .ram     (ram),
    .rd_data (rd_data)
  );

endmodule
`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer testbench
// Sends console commands over the request channel and tracks screen, cursor
// and registers in a local model. Every response beat is compared field by
// field with the oldest pending prediction. The run has a short directed
// table, a fill of the screen down to the bottom row, and several randomized
// phases under different color and protected-column settings. Both channels
// stall at random, with one long response hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import tcw_pkg::*;

  localparam int WATCHDOG_CYCLES = 20000;
  localparam int LONG_HOLD       = 600;
  localparam int DRAIN_CYCLES    = 50;
  localparam int MIX_ITEMS       = 225;
  localparam int MAX_REPORTS     = 10;

  localparam logic [2:0] CMD_RSV_LO  = 3'd5;
  localparam logic [2:0] CMD_RSV_MID = 3'd6;
  localparam logic [2:0] CMD_RSV_HI  = 3'd7;
  localparam logic [1:0] CFG_SPARE_A = 2'd2;
  localparam logic [1:0] CFG_SPARE_B = 2'd3;

  typedef struct {
    req_t cmd;
    bit   fixed;
    rsp_t rsp;
  } plan_row_t;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_ready;
  req_t       req       = '0;
  logic       rsp_valid;
  logic       rsp_ready = 1'b0;
  rsp_t       rsp;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data  = '0;

  // local copy of the console
  logic [CELL_W-1:0] screen [CELLS];
  logic [ROW_W-1:0]  cur_row   = '0;
  logic [COL_W-1:0]  cur_col   = '0;
  logic [7:0]        cur_color = TEXT_COLOR_RESET;
  logic [COL_W-1:0]  cur_prot  = '0;

  rsp_t pending_q[$];
  int   n_cmds = 0, n_reads = 0, n_scrolls = 0, n_clears = 0, n_cfg = 0;
  int   n_beats = 0, n_bad = 0;
  int   burst_left = 0;
  int   quiet = 0;
  bit   hold_req = 1'b0, hold_done = 1'b0;

  text_console_writer dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic req_t cmd_word(input logic [2:0] op, input logic [7:0] ch,
                                    input logic [7:0] color, input logic [ROW_W-1:0] r,
                                    input logic [COL_W-1:0] c);
    req_t w;
    w.command    = op;
    w.char_code  = ch;
    w.cell_color = color;
    w.row        = r;
    w.col        = c;
    return w;
  endfunction

  function automatic plan_row_t plan(input logic [2:0] op, input logic [7:0] ch,
                                     input logic [7:0] color, input logic [ROW_W-1:0] r,
                                     input logic [COL_W-1:0] c, input bit fixed,
                                     input logic [ROW_W-1:0] er, input logic [COL_W-1:0] ec,
                                     input logic [CELL_W-1:0] cell_exp);
    plan_row_t p;
    p.cmd                = cmd_word(op, ch, color, r, c);
    p.fixed              = fixed;
    p.rsp.cursor_row     = er;
    p.rsp.cursor_col     = ec;
    p.rsp.scrolled       = 1'b0;
    p.rsp.cell_value     = cell_exp;
    return p;
  endfunction

  // applies one command to the local console and returns the response it owes
  function automatic rsp_t console_apply(input req_t c);
    rsp_t o;
    int   i;
    int   at;
    bit   hit;
    o   = '0;
    hit = (c.row < ROWS) && (c.col < COLUMNS);
    at  = int'(c.row) * COLUMNS + int'(c.col);
    case (c.command)
      CMD_PUTCHAR: begin
        screen[int'(cur_row) * COLUMNS + int'(cur_col)] = {cur_color, c.char_code};
        if (cur_col == COLUMNS - 1) begin
          cur_col = '0;
          if (cur_row == ROWS - 1) begin
            for (i = 0; i < COPY_N; i++) screen[i] = screen[i + COLUMNS];
            for (i = COPY_N; i < CELLS; i++) screen[i] = {cur_color, BLANK_CHAR};
            o.scrolled = 1'b1;
            n_scrolls++;
          end else begin
            cur_row++;
          end
        end else begin
          cur_col++;
        end
      end
      CMD_BACKSPACE: begin
        if (cur_col > cur_prot) begin
          cur_col--;
          screen[int'(cur_row) * COLUMNS + int'(cur_col)] = {cur_color, BLANK_CHAR};
        end
      end
      CMD_CLEAR: begin
        for (i = 0; i < CELLS; i++) screen[i] = {cur_color, BLANK_CHAR};
        cur_row = '0;
        cur_col = '0;
        n_clears++;
      end
      CMD_PUTAT: begin
        if (hit) screen[at] = {c.cell_color, c.char_code};
      end
      CMD_READ: begin
        n_reads++;
        if (hit) o.cell_value = screen[at];
      end
      default: ;
    endcase
    o.cursor_row = cur_row;
    o.cursor_col = cur_col;
    return o;
  endfunction

  // sender: bursts of random length separated by random gaps
  task automatic send_cmd(input req_t c, input bit fixed, input rsp_t fixed_rsp);
    rsp_t p;
    int   gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 12));
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? int'($urandom_range(30, 80))
                                               : int'($urandom_range(1, 12));
    end
    burst_left--;
    req_valid <= 1'b1;
    req       <= c;
    do @(posedge clk); while (!req_ready);
    p = console_apply(c);
    pending_q.push_back(fixed ? fixed_rsp : p);
    n_cmds++;
  endtask

  task automatic send_free(input req_t c);
    send_cmd(c, 1'b0, '0);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_q.size() != 0);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_TEXT_COLOR: cur_color = val;
      CFG_PROT_COLS:  cur_prot  = val[COL_W-1:0];
      default: ;
    endcase
    n_cfg++;
  endtask

  task automatic set_config(input logic [7:0] color, input logic [7:0] prot, input bit spare);
    cfg_write(CFG_TEXT_COLOR, color);
    cfg_write(CFG_PROT_COLS, prot);
    if (spare) begin
      // unmapped indexes must leave both registers alone
      cfg_write(CFG_SPARE_A, ~color);
      cfg_write(CFG_SPARE_B, 8'hFF);
    end
    cfg_valid <= 1'b0;
  endtask

  // random sequences: typing runs, backspace runs, write-then-read pairs,
  // reads, and a little noise that does not count toward the quota
  task automatic run_mix(input int quota);
    int               counted;
    int               kind;
    int               n;
    logic [ROW_W-1:0] r;
    logic [COL_W-1:0] c;
    counted = 0;
    while (counted < quota) begin
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        n = $urandom_range(1, 40);
        repeat (n) send_free(cmd_word(CMD_PUTCHAR, 8'($urandom_range(0, 255)),
                                      8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                                      7'($urandom_range(0, 127))));
        counted += n;
      end else if (kind < 64) begin
        n = $urandom_range(1, 12);
        repeat (n) send_free(cmd_word(CMD_BACKSPACE, 8'($urandom_range(0, 255)),
                                      8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                                      7'($urandom_range(0, 127))));
        counted += n;
      end else if (kind < 77) begin
        r = ROW_W'($urandom_range(0, ROWS - 1));
        c = COL_W'($urandom_range(0, COLUMNS - 1));
        send_free(cmd_word(CMD_PUTAT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           r, c));
        send_free(cmd_word(CMD_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           r, c));
        counted += 2;
      end else if (kind < 94) begin
        // half of the reads look at the cursor row, where backspace and scroll land
        r = ($urandom_range(0, 1) == 0) ? cur_row : ROW_W'($urandom_range(0, ROWS - 1));
        c = COL_W'($urandom_range(0, COLUMNS - 1));
        send_free(cmd_word(CMD_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           r, c));
        counted += 1;
      end else begin
        case ($urandom_range(0, 3))
          0: send_free(cmd_word(3'($urandom_range(CMD_RSV_LO, CMD_RSV_HI)),
                                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                5'($urandom_range(0, 31)), 7'($urandom_range(0, 127))));
          1: send_free(cmd_word(CMD_PUTAT, 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255)), 5'($urandom_range(ROWS, 31)),
                                7'($urandom_range(0, 127))));
          2: send_free(cmd_word(CMD_PUTAT, 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                                7'($urandom_range(COLUMNS, 127))));
          default: send_free(cmd_word(CMD_READ, 8'($urandom_range(0, 255)),
                                      8'($urandom_range(0, 255)),
                                      5'($urandom_range(ROWS, 31)),
                                      7'($urandom_range(0, 127))));
        endcase
      end
    end
  endtask

  // response side: its own stall pattern, plus one long hold-off on request
  initial begin : receiver
    int mode;
    int span;
    int k;
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        rsp_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 2);
        span = $urandom_range(4, 60);
        for (k = 0; k < span; k++) begin
          case (mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= ($urandom_range(0, 2) != 0);
            default: rsp_ready <= ((k % 5) < 3);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      n_beats++;
      if (pending_q.size() == 0) begin
        n_bad++;
        if (n_bad <= MAX_REPORTS)
          $display("unexpected result beat: row %0d col %0d scrolled %0b cell %h",
                   rsp.cursor_row, rsp.cursor_col, rsp.scrolled, rsp.cell_value);
      end else begin
        want = pending_q.pop_front();
        if (rsp.cursor_row !== want.cursor_row || rsp.cursor_col !== want.cursor_col ||
            rsp.scrolled !== want.scrolled || rsp.cell_value !== want.cell_value) begin
          n_bad++;
          if (n_bad <= MAX_REPORTS)
            $display("beat %0d: expected row %0d col %0d scrolled %0b cell %h, got row %0d col %0d scrolled %0b cell %h",
                     n_beats, want.cursor_row, want.cursor_col, want.scrolled,
                     want.cell_value, rsp.cursor_row, rsp.cursor_col, rsp.scrolled,
                     rsp.cell_value);
        end
      end
    end
  end

  // watchdog: cycles with no beat on any channel
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
        (cfg_valid && cfg_ready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= WATCHDOG_CYCLES) begin
      $display("no beat for %0d cycles", quiet);
      $display("text_console_writer: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    plan_row_t directed[$];
    int        i;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // cursor and cells as left by reset, clear, corners and out-of-range targets
    directed.push_back(plan(CMD_PUTCHAR,   8'h48, 8'h00, 5'd0,  7'd0,   1'b1, 5'd0, 7'd1, 16'h0000));
    directed.push_back(plan(CMD_CLEAR,     8'h00, 8'h00, 5'd0,  7'd0,   1'b1, 5'd0, 7'd0, 16'h0000));
    directed.push_back(plan(CMD_READ,      8'h00, 8'h00, 5'd0,  7'd0,   1'b1, 5'd0, 7'd0, 16'h0F20));
    directed.push_back(plan(CMD_READ,      8'h00, 8'h00, 5'd24, 7'd79,  1'b1, 5'd0, 7'd0, 16'h0F20));
    directed.push_back(plan(CMD_PUTCHAR,   8'h00, 8'hFF, 5'd31, 7'd127, 1'b1, 5'd0, 7'd1, 16'h0000));
    directed.push_back(plan(CMD_PUTCHAR,   8'hFF, 8'h00, 5'd0,  7'd0,   1'b1, 5'd0, 7'd2, 16'h0000));
    directed.push_back(plan(CMD_READ,      8'h00, 8'h00, 5'd0,  7'd0,   1'b1, 5'd0, 7'd2, 16'h0F00));
    directed.push_back(plan(CMD_READ,      8'h00, 8'h00, 5'd0,  7'd1,   1'b1, 5'd0, 7'd2, 16'h0FFF));
    directed.push_back(plan(CMD_PUTAT,     8'hFF, 8'hFF, 5'd24, 7'd79,  1'b1, 5'd0, 7'd2, 16'h0000));
    directed.push_back(plan(CMD_READ,      8'h00, 8'h00, 5'd24, 7'd79,  1'b1, 5'd0, 7'd2, 16'hFFFF));
    directed.push_back(plan(CMD_PUTAT,     8'h00, 8'h00, 5'd0,  7'd0,   1'b1, 5'd0, 7'd2, 16'h0000));
    directed.push_back(plan(CMD_READ,      8'h00, 8'h00, 5'd0,  7'd0,   1'b1, 5'd0, 7'd2, 16'h0000));
    directed.push_back(plan(CMD_PUTAT,     8'hAA, 8'h55, 5'd25, 7'd0,   1'b1, 5'd0, 7'd2, 16'h0000));
    directed.push_back(plan(CMD_PUTAT,     8'h55, 8'hAA, 5'd31, 7'd127, 1'b1, 5'd0, 7'd2, 16'h0000));
    directed.push_back(plan(CMD_PUTAT,     8'h11, 8'h22, 5'd0,  7'd80,  1'b1, 5'd0, 7'd2, 16'h0000));
    directed.push_back(plan(CMD_READ,      8'h00, 8'h00, 5'd31, 7'd127, 1'b1, 5'd0, 7'd2, 16'h0000));
    directed.push_back(plan(CMD_READ,      8'h00, 8'h00, 5'd0,  7'd80,  1'b1, 5'd0, 7'd2, 16'h0000));
    directed.push_back(plan(CMD_READ,      8'h00, 8'h00, 5'd25, 7'd0,   1'b1, 5'd0, 7'd2, 16'h0000));
    directed.push_back(plan(CMD_BACKSPACE, 8'h00, 8'h00, 5'd0,  7'd0,   1'b1, 5'd0, 7'd1, 16'h0000));
    directed.push_back(plan(CMD_READ,      8'h00, 8'h00, 5'd0,  7'd1,   1'b1, 5'd0, 7'd1, 16'h0F20));
    directed.push_back(plan(CMD_BACKSPACE, 8'h00, 8'h00, 5'd0,  7'd0,   1'b1, 5'd0, 7'd0, 16'h0000));
    // backspace at column zero does nothing
    directed.push_back(plan(CMD_BACKSPACE, 8'h00, 8'h00, 5'd0,  7'd0,   1'b1, 5'd0, 7'd0, 16'h0000));
    directed.push_back(plan(CMD_READ,      8'h00, 8'h00, 5'd0,  7'd0,   1'b1, 5'd0, 7'd0, 16'h0F20));
    directed.push_back(plan(CMD_RSV_LO,    8'hFF, 8'hFF, 5'd31, 7'd127, 1'b1, 5'd0, 7'd0, 16'h0000));
    directed.push_back(plan(CMD_RSV_MID,   8'h5A, 8'hA5, 5'd24, 7'd79,  1'b0, 5'd0, 7'd0, 16'h0000));
    directed.push_back(plan(CMD_RSV_HI,    8'hFF, 8'h00, 5'd0,  7'd0,   1'b0, 5'd0, 7'd0, 16'h0000));
    for (i = 0; i < directed.size(); i++)
      send_cmd(directed[i].cmd, directed[i].fixed, directed[i].rsp);

    // type down to the bottom row so later phases wrap and scroll
    drain();
    set_config(8'h00, 8'd0, 1'b0);
    while (!(cur_row == ROWS - 1 && cur_col >= 40)) begin
      case ($urandom_range(0, 19))
        18: send_free(cmd_word(CMD_READ, 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)),
                               ROW_W'($urandom_range(0, ROWS - 1)),
                               COL_W'($urandom_range(0, COLUMNS - 1))));
        19: send_free(cmd_word(CMD_PUTAT, 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)),
                               ROW_W'($urandom_range(0, ROWS - 1)),
                               COL_W'($urandom_range(0, COLUMNS - 1))));
        default: send_free(cmd_word(CMD_PUTCHAR, 8'($urandom_range(0, 255)),
                                    8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                                    7'($urandom_range(0, 127))));
      endcase
    end

    drain();
    set_config(8'hFF, 8'd80, 1'b1);
    run_mix(MIX_ITEMS);

    drain();
    set_config(8'h0F, 8'd40, 1'b0);
    hold_req = 1'b1;
    run_mix(MIX_ITEMS);

    drain();
    set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, COLUMNS)), 1'b0);
    run_mix(MIX_ITEMS);

    // clear in a random color, then protect only column zero
    drain();
    set_config(8'($urandom_range(1, 254)), 8'd1, 1'b0);
    send_free(cmd_word(CMD_CLEAR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       5'($urandom_range(0, 31)), 7'($urandom_range(0, 127))));
    run_mix(MIX_ITEMS);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d commands sent: %0d reads, %0d scrolls, %0d clears, %0d register writes",
             n_cmds, n_reads, n_scrolls, n_clears, n_cfg);
    $display("%0d result beats compared, %0d wrong or unexpected", n_beats, n_bad);
    if (n_bad == 0 && pending_q.size() == 0)
      $display("text_console_writer: match");
    else
      $display("text_console_writer: mismatch");
    $finish;
  end

endmodule
